>>> hdl/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// shared constants, codes and controller/datapath interface types for the
// fading lifetime table
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int DEPTH     = 32;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int TIME_BITS = 24;
  localparam int ID_W      = 32;
  localparam int ALPHA_W   = 16;
  localparam int Q_BITS    = 15;

  localparam logic [ALPHA_W-1:0] ONE_Q15 = 16'h8000;

  localparam logic [2:0] CMD_SPAWN   = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_SETLIFE = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [1:0] EV_SPAWNED = 2'd0;
  localparam logic [1:0] EV_REMOVED = 2'd1;
  localparam logic [1:0] EV_QUERY   = 2'd2;
  localparam logic [1:0] EV_DONE    = 2'd3;

  localparam logic [3:0] OP_IDLE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_EVICT   = 4'd2;
  localparam logic [3:0] OP_SPAWN   = 4'd3;
  localparam logic [3:0] OP_DONE    = 4'd4;
  localparam logic [3:0] OP_QANS    = 4'd5;
  localparam logic [3:0] OP_SETLIFE = 4'd6;
  localparam logic [3:0] OP_NEXT    = 4'd7;
  localparam logic [3:0] OP_PCLR    = 4'd8;
  localparam logic [3:0] OP_MARK    = 4'd9;
  localparam logic [3:0] OP_CNT     = 4'd10;
  localparam logic [3:0] OP_GONE    = 4'd11;
  localparam logic [3:0] OP_COMPACT = 4'd12;
  localparam logic [3:0] OP_AGE     = 4'd13;
  localparam logic [3:0] OP_WALPHA  = 4'd14;
  localparam logic [3:0] OP_CLEAR   = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       lim_hit;
    logic       ptr_end;
    logic       match;
    logic       gone_at;
    logic       age_div;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> hdl/flt_div.sv
// ----------------------------------------------------------------------------
// flt_div
// restoring divider for fade ramps: floor(num * 2^15 / den), num below den
// ----------------------------------------------------------------------------
module flt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [flt_pkg::TIME_BITS-1:0]   num,
  input  logic [flt_pkg::TIME_BITS-1:0]   den,
  output logic                            done,
  output logic [flt_pkg::ALPHA_W-1:0]     quo
);
  import flt_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [3:0]           cnt_r;
  logic [TIME_BITS:0]   rem_r;
  logic [TIME_BITS-1:0] den_r;
  logic [Q_BITS-1:0]    quo_r;
  logic [TIME_BITS:0]   rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r[TIME_BITS-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 4'(Q_BITS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(Q_BITS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[Q_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = {1'b0, quo_r};

endmodule

>>> hdl/flt_dp.sv
// ----------------------------------------------------------------------------
// flt_dp
// entry table, walk pointer, kill/expiry flags, fade arithmetic and the
// result register
// ----------------------------------------------------------------------------
module flt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  flt_pkg::dp_cmd_t               cmd,
  output flt_pkg::dp_stat_t              stat,
  input  logic [2:0]                     in_cmd,
  input  logic [flt_pkg::ID_W-1:0]       in_id,
  input  logic [flt_pkg::TIME_BITS-1:0]  in_fin,
  input  logic [flt_pkg::TIME_BITS-1:0]  in_fout,
  input  logic [flt_pkg::TIME_BITS-1:0]  in_life,
  input  logic [flt_pkg::TIME_BITS-1:0]  in_step,
  input  logic                           cfg_we,
  input  logic [flt_pkg::CNT_W-1:0]      cfg_data,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic [flt_pkg::ID_W-1:0]       out_id,
  output logic                           out_found,
  output logic [flt_pkg::ALPHA_W-1:0]    out_fade,
  output logic [flt_pkg::CNT_W-1:0]      out_count,
  output logic                           out_last
);
  import flt_pkg::*;

  logic [2:0]           cmd_r;
  logic [ID_W-1:0]      key_r;
  logic [TIME_BITS-1:0] fin_r, fout_r, life_r, step_r;
  logic [CNT_W-1:0]     count_r, max_r, live_r, ptr_r;
  logic [ID_W-1:0]      serial_r;
  logic                 out_valid_r;
  logic [DEPTH-1:0]     kill_r, gone_r;

  logic [ID_W-1:0]      id_r    [DEPTH];
  logic [TIME_BITS-1:0] age_r   [DEPTH];
  logic [TIME_BITS-1:0] fi_r    [DEPTH];
  logic [TIME_BITS-1:0] fo_r    [DEPTH];
  logic [TIME_BITS-1:0] lt_r    [DEPTH];
  logic [ALPHA_W-1:0]   alpha_r [DEPTH];

  logic [1:0]           okind_r;
  logic [ID_W-1:0]      oid_r;
  logic                 ofound_r;
  logic [ALPHA_W-1:0]   ofade_r;
  logic [CNT_W-1:0]     ocount_r;
  logic                 olast_r;

  logic [IDX_W-1:0]     pidx, sh_from;
  logic                 ptr_end, do_shift, out_load;
  logic [CNT_W-1:0]     lim, live_c;
  logic [TIME_BITS:0]   age_sum;
  logic [TIME_BITS-1:0] a_sat, rem, div_num, div_den;
  logic                 age_div, gone_now;
  logic [ALPHA_W-1:0]   alpha_now, div_quo;
  logic                 div_done;
  logic [ID_W-1:0]      mark_key, done_id;
  logic [DEPTH-1:0]     match_v, kill_sh, kill_shifted;

  assign pidx    = ptr_r[IDX_W-1:0];
  assign ptr_end = ptr_r >= count_r;
  assign lim     = (max_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_r;

  // tick decision for the entry under the pointer
  always_comb begin
    age_sum   = {1'b0, age_r[pidx]} + {1'b0, step_r};
    a_sat     = age_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : age_sum[TIME_BITS-1:0];
    rem       = lt_r[pidx] - a_sat;
    age_div   = 1'b0;
    gone_now  = 1'b0;
    alpha_now = ONE_Q15;
    div_num   = a_sat;
    div_den   = fi_r[pidx];
    if (fi_r[pidx] != '0 && a_sat < fi_r[pidx]) begin
      age_div = 1'b1;
    end else if (lt_r[pidx] != '0) begin
      if (a_sat >= lt_r[pidx]) begin
        gone_now = 1'b1;
      end else if (fo_r[pidx] != '0 && rem < fo_r[pidx]) begin
        age_div = 1'b1;
        div_num = rem;
        div_den = fo_r[pidx];
      end
    end
  end

  assign mark_key = (cmd_r == CMD_TICK) ? id_r[pidx] : key_r;
  assign done_id  = (cmd_r == CMD_DESTROY || cmd_r == CMD_SETLIFE) ? key_r : '0;

  always_comb begin
    live_c = '0;
    for (int j = 0; j < DEPTH; j++) begin
      match_v[j] = (CNT_W'(j) < count_r) && (id_r[j] == mark_key);
      live_c     = live_c + CNT_W'((CNT_W'(j) < count_r) && !kill_r[j]);
    end
  end

  assign do_shift = (cmd.op == OP_EVICT) || (cmd.op == OP_COMPACT && kill_r[pidx]);
  assign sh_from  = (cmd.op == OP_EVICT) ? '0 : pidx;
  assign kill_sh  = {1'b0, kill_r[DEPTH-1:1]};
  assign out_load = cmd.op inside {OP_EVICT, OP_SPAWN, OP_DONE, OP_QANS, OP_GONE};

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      kill_shifted[j] = (IDX_W'(j) >= sh_from) ? kill_sh[j] : kill_r[j];
    end
  end

  flt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_AGE && !ptr_end && age_div),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      serial_r    <= ID_W'(1);
      ptr_r       <= '0;
      max_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
      kill_r      <= '0;
      gone_r      <= '0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          ptr_r  <= '0;
          kill_r <= '0;
          gone_r <= '0;
        end
        OP_EVICT: begin
          count_r <= count_r - CNT_W'(1);
          kill_r  <= kill_shifted;
        end
        OP_SPAWN: begin
          count_r  <= count_r + CNT_W'(1);
          serial_r <= serial_r + ID_W'(1);
        end
        OP_GONE: begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
        OP_NEXT, OP_WALPHA: begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
        OP_PCLR: begin
          ptr_r <= '0;
        end
        OP_MARK: begin
          kill_r <= kill_r | match_v;
        end
        OP_COMPACT: begin
          if (kill_r[pidx]) begin
            count_r <= count_r - CNT_W'(1);
            kill_r  <= kill_shifted;
          end else begin
            ptr_r <= ptr_r + CNT_W'(1);
          end
        end
        OP_AGE: begin
          if (gone_now) begin
            gone_r[pidx] <= 1'b1;
          end
          if (!age_div) begin
            ptr_r <= ptr_r + CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (IDX_W'(j) >= sh_from) begin
          id_r[j]    <= id_r[j+1];
          age_r[j]   <= age_r[j+1];
          fi_r[j]    <= fi_r[j+1];
          fo_r[j]    <= fo_r[j+1];
          lt_r[j]    <= lt_r[j+1];
          alpha_r[j] <= alpha_r[j+1];
        end
      end
    end
    case (cmd.op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        key_r  <= in_id;
        fin_r  <= in_fin;
        fout_r <= in_fout;
        life_r <= in_life;
        step_r <= in_step;
      end
      OP_EVICT: begin
        okind_r  <= EV_REMOVED;
        oid_r    <= id_r[0];
        ofound_r <= 1'b0;
        ofade_r  <= '0;
        ocount_r <= count_r - CNT_W'(1);
        olast_r  <= 1'b0;
      end
      OP_SPAWN: begin
        id_r[count_r[IDX_W-1:0]]    <= serial_r;
        age_r[count_r[IDX_W-1:0]]   <= '0;
        fi_r[count_r[IDX_W-1:0]]    <= fin_r;
        fo_r[count_r[IDX_W-1:0]]    <= fout_r;
        lt_r[count_r[IDX_W-1:0]]    <= life_r;
        alpha_r[count_r[IDX_W-1:0]] <= (fin_r == '0) ? ONE_Q15 : '0;
        okind_r  <= EV_SPAWNED;
        oid_r    <= serial_r;
        ofound_r <= 1'b0;
        ofade_r  <= '0;
        ocount_r <= count_r + CNT_W'(1);
        olast_r  <= 1'b1;
      end
      OP_DONE: begin
        okind_r  <= EV_DONE;
        oid_r    <= done_id;
        ofound_r <= 1'b0;
        ofade_r  <= '0;
        ocount_r <= count_r;
        olast_r  <= 1'b1;
      end
      OP_QANS: begin
        okind_r  <= EV_QUERY;
        oid_r    <= key_r;
        ofound_r <= !ptr_end;
        ofade_r  <= ptr_end ? '0 : alpha_r[pidx];
        ocount_r <= count_r;
        olast_r  <= 1'b1;
      end
      OP_GONE: begin
        okind_r  <= EV_REMOVED;
        oid_r    <= id_r[pidx];
        ofound_r <= 1'b0;
        ofade_r  <= '0;
        ocount_r <= live_r;
        olast_r  <= 1'b0;
      end
      OP_SETLIFE: begin
        if (!ptr_end) begin
          lt_r[pidx] <= life_r;
        end
      end
      OP_CNT: begin
        live_r <= live_c;
      end
      OP_AGE: begin
        age_r[pidx] <= a_sat;
        if (!age_div && !gone_now) begin
          alpha_r[pidx] <= alpha_now;
        end
      end
      OP_WALPHA: begin
        alpha_r[pidx] <= div_quo;
      end
      default: begin
      end
    endcase
  end

  assign stat.cmd      = cmd_r;
  assign stat.lim_hit  = (count_r >= lim) && (count_r != '0);
  assign stat.ptr_end  = ptr_end;
  assign stat.match    = !ptr_end && (id_r[pidx] == key_r);
  assign stat.gone_at  = gone_r[pidx];
  assign stat.age_div  = age_div;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_valid = out_valid_r;
  assign out_kind  = okind_r;
  assign out_id    = oid_r;
  assign out_found = ofound_r;
  assign out_fade  = ofade_r;
  assign out_count = ocount_r;
  assign out_last  = olast_r;

endmodule

>>> hdl/flt_ctrl.sv
// ----------------------------------------------------------------------------
// flt_ctrl
// sequencer for spawn, destroy, set lifetime, lookup, tick and clear requests
// ----------------------------------------------------------------------------
module flt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  flt_pkg::dp_stat_t  stat,
  output flt_pkg::dp_cmd_t   cmd
);
  import flt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_EVICT = 4'd2;
  localparam logic [3:0] S_DMARK = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_QANS  = 4'd5;
  localparam logic [3:0] S_AGE   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_P2    = 4'd8;
  localparam logic [3:0] S_CNT   = 4'd9;
  localparam logic [3:0] S_GONE  = 4'd10;
  localparam logic [3:0] S_CMP   = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_SPAWN:              state_nxt = S_EVICT;
          CMD_DESTROY:            state_nxt = S_DMARK;
          CMD_SETLIFE, CMD_QUERY: state_nxt = S_FIND;
          CMD_TICK:               state_nxt = S_AGE;
          CMD_CLEAR:              state_nxt = S_CLR;
          default:                state_nxt = S_DONE;
        endcase
      end
      S_EVICT: begin
        if (stat.out_free) begin
          if (stat.lim_hit) begin
            cmd.op = OP_EVICT;
          end else begin
            cmd.op    = OP_SPAWN;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DMARK: begin
        cmd.op    = OP_MARK;
        state_nxt = S_CMP;
      end
      S_FIND: begin
        if (stat.ptr_end || stat.match) begin
          if (stat.cmd == CMD_QUERY) begin
            state_nxt = S_QANS;
          end else begin
            cmd.op    = OP_SETLIFE;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.op = OP_NEXT;
        end
      end
      S_QANS: begin
        if (stat.out_free) begin
          cmd.op    = OP_QANS;
          state_nxt = S_IDLE;
        end
      end
      S_AGE: begin
        if (stat.ptr_end) begin
          cmd.op    = OP_PCLR;
          state_nxt = S_P2;
        end else begin
          cmd.op = OP_AGE;
          if (stat.age_div) begin
            state_nxt = S_DIVW;
          end
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.op    = OP_WALPHA;
          state_nxt = S_AGE;
        end
      end
      S_P2: begin
        if (stat.ptr_end) begin
          cmd.op    = OP_PCLR;
          state_nxt = S_CMP;
        end else if (stat.gone_at) begin
          cmd.op    = OP_MARK;
          state_nxt = S_CNT;
        end else begin
          cmd.op = OP_NEXT;
        end
      end
      S_CNT: begin
        cmd.op    = OP_CNT;
        state_nxt = S_GONE;
      end
      S_GONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_GONE;
          state_nxt = S_P2;
        end
      end
      S_CMP: begin
        if (stat.ptr_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_COMPACT;
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

>>> hdl/fading_lifetime_table.sv
// ----------------------------------------------------------------------------
// fading_lifetime_table
// timed entry table in insertion order with eviction, expiry and fade ramps
// ----------------------------------------------------------------------------
// spawn: the oldest entries are evicted while the table is at its budget, then
//   the spawn; destroy: mark, then compaction; query and set lifetime: id search
// tick: a walk ages each entry, a fading one via the 15-step divider;
//   a second walk reports each expired entry, then compaction
// one request in flight at a time; the result register lets the next request in
// reset: synchronous, table empty, id counter at one, budget 32, no clearing pass
module fading_lifetime_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_id, fade_in_time, fade_out_time, life_time, time_step
  input  logic [127:0] in_tdata,
  // cmd
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_id, found, fade_level, entry_count, zero pad
  output logic [55:0]  out_tdata,
  // event_kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);
  import flt_pkg::*;

  dp_cmd_t          dcmd;
  dp_stat_t         dstat;
  logic [ID_W-1:0]  o_id;
  logic             o_found;
  logic [ALPHA_W-1:0] o_fade;
  logic [CNT_W-1:0] o_count;

  assign cfg_ready = 1'b1;

  flt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dstat),
    .cmd       (dcmd)
  );

  flt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dcmd),
    .stat       (dstat),
    .in_cmd     (in_tuser),
    .in_id      (in_tdata[31:0]),
    .in_fin     (in_tdata[55:32]),
    .in_fout    (in_tdata[79:56]),
    .in_life    (in_tdata[103:80]),
    .in_step    (in_tdata[127:104]),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_id     (o_id),
    .out_found  (o_found),
    .out_fade   (o_fade),
    .out_count  (o_count),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, o_count, o_fade, o_found, o_id};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_count <= CNT_W'(DEPTH)))
    else $error("entry count above table depth");

  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_fade <= ONE_Q15))
    else $error("fade level above full scale");

  a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_QUERY || out_tuser == EV_SPAWNED)) |-> out_tlast)
    else $error("query or spawn result not marked last");

endmodule
